>>> rtl/wfba_pkg.sv
`default_nettype none

package wfba_pkg;

	localparam int MAX_BLOCKS_DEF = 32;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int CFG_W      = 6;
	localparam int IDX_FIELD_W = 5;
	localparam int SIZE_FIELD_W = 16;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	typedef struct packed {
		logic                    mode;
		logic [IDX_FIELD_W-1:0]  block_index;
		logic [SIZE_FIELD_W-1:0] size;
	} in_item_t;

	typedef struct packed {
		logic                    allocated;
		logic [IDX_FIELD_W-1:0]  chosen_block;
		logic [SIZE_FIELD_W-1:0] chosen_block_size;
		logic [SIZE_FIELD_W-1:0] leftover;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> rtl/wfba_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered read data.
module wfba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/worst_fit_block_allocator.sv
`default_nettype none

// Worst-fit block allocator. The block keeps a table of MAX_BLOCKS memory blocks, each with a
// size held in a small RAM and a used flag held in flip-flops that reset clears, so every block
// starts out free. A load transfer (mode 0) writes one block's size and marks it free; it
// produces no result, and a load whose index lies beyond the table is dropped. A request
// transfer (mode 1) carries a file size. The block then walks the first block_count entries
// (saturated to MAX_BLOCKS), one RAM read per cycle through a single comparator, and keeps
// the largest free block that still fits, the lowest index winning a tie. The winner is
// marked used and reported with its size and the leftover fragment; if nothing fits, a result
// with allocated low and all other fields zero is returned. After a request transfer the input
// stays stalled while the sequencer reads each entry in turn, takes the registered RAM read
// data, sees the scan pipeline empty and commits the result; with a count of zero nothing is
// read. The commit also waits while an earlier result still sits stalled in the output
// register. The block thus takes no new item until the request has committed, and the single
// read port of the size RAM lets the scan read only one entry at a time.
// Results sit in an output register, so a finished result may wait for its transfer while the
// next item is taken. Every block size must be loaded before a request scans over it.
// block_count may only be written while the block is idle.
module worst_fit_block_allocator
	import wfba_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wen,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_item_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_item_t             out_data
);

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

	// Configuration register.
	logic [CFG_W-1:0] block_count_q;

	// Sequencer state.
	state_t state_q, state_d;

	// Request context.
	logic [SIZE_BITS-1:0] req_size_q;
	logic [CNT_W-1:0]     limit_q;
	logic [CNT_W-1:0]     rd_cnt_q;

	// Compare stage, aligned with the registered RAM read data.
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	// Best candidate found so far.
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;

	logic [MAX_BLOCKS-1:0] used_q;

	logic                 out_valid_q;
	out_item_t            out_data_q;

	// Control decoded from the state.
	logic in_take;
	logic issue;
	logic commit;

	logic                 load_hit;
	logic                 req_take;
	logic [CMP_W-1:0]     count_ext;
	logic [CMP_W-1:0]     limit_ext;
	logic [IDX_W-1:0]     load_addr;
	logic [SIZE_BITS-1:0] in_size;
	logic [SIZE_BITS-1:0] rd_size;
	logic                 cand_hit;

	assign in_size   = SIZE_BITS'(in_data.size);
	assign load_addr = IDX_W'(in_data.block_index);
	assign load_hit  = in_take && (in_data.mode == MODE_LOAD) &&
		(32'(in_data.block_index) < 32'(MAX_BLOCKS));
	assign req_take  = in_take && (in_data.mode == MODE_REQUEST);

	// A count above the table size saturates to the table size.
	assign count_ext = CMP_W'(block_count_q);
	assign limit_ext = (count_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : count_ext;

	wfba_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(MAX_BLOCKS)
	) u_size_ram (
		.clk  (clk),
		.we   (load_hit),
		.waddr(load_addr),
		.wdata(in_size),
		.raddr(rd_cnt_q[IDX_W-1:0]),
		.rdata(rd_size)
	);

	// A free entry that fits replaces the best only when strictly larger, so the lowest index
	// wins among equal sizes.
	assign cand_hit = vld_s1 && !used_q[idx_s1] && (rd_size >= req_size_q) &&
		(!found_q || (rd_size > best_size_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issue && !vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		commit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SCAN: begin
				issue = (rd_cnt_q < limit_q);
			end
			ST_DONE: begin
				// The result register must be empty or emptying this cycle.
				commit = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= '0;
			state_q       <= ST_IDLE;
			rd_cnt_q      <= '0;
			limit_q       <= '0;
			vld_s1        <= 1'b0;
			found_q       <= 1'b0;
			used_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				block_count_q <= cfg_wdata;
			end
			if (req_take) begin
				limit_q  <= CNT_W'(limit_ext);
				rd_cnt_q <= '0;
				found_q  <= 1'b0;
			end
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			vld_s1 <= issue;
			if (cand_hit) begin
				found_q <= 1'b1;
			end
			// Loading a block always frees it, even if it was taken before.
			if (load_hit) begin
				used_q[load_addr] <= 1'b0;
			end
			if (commit && found_q) begin
				used_q[best_idx_q] <= 1'b1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_size_q <= in_size;
		end
		if (issue) begin
			idx_s1 <= rd_cnt_q[IDX_W-1:0];
		end
		if (cand_hit) begin
			best_idx_q  <= idx_s1;
			best_size_q <= rd_size;
		end
		if (commit) begin
			if (found_q) begin
				out_data_q.allocated         <= 1'b1;
				out_data_q.chosen_block      <= IDX_FIELD_W'(best_idx_q);
				out_data_q.chosen_block_size <= SIZE_FIELD_W'(best_size_q);
				out_data_q.leftover          <= SIZE_FIELD_W'(best_size_q - req_size_q);
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

>>> tb/worst_fit_block_allocator_tb.sv
`timescale 1ns / 100ps

module worst_fit_block_allocator_tb;
	import wfba_pkg::*;

	// Time a request may keep the block busy: a read of every table entry plus the accept,
	// the read latency and the commit, with some margin on top.
	localparam int SETTLE_CYCLES  = MAX_BLOCKS_DEF + 8;
	// The long receiver hold-off that fills the block and backs up its input.
	localparam int HOLD_CYCLES    = 400;
	// Cycles without any transfer after which the run is declared hung.
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS    = 150;
	localparam int PHASE_COUNT    = 13;

	// Shadow of the allocator. It keeps its own table of sizes and used flags, predicts the
	// result of every request transfer when the transfer is accepted, and compares the results
	// that come out of the block against those predictions in order.
	class alloc_scoreboard;
		logic [SIZE_FIELD_W-1:0] sizes [MAX_BLOCKS_DEF];
		bit                      loaded [MAX_BLOCKS_DEF];
		bit                      taken [MAX_BLOCKS_DEF];
		logic [CFG_W-1:0]        count;
		out_item_t               pending [$];
		int                      errors;
		int                      loads;
		int                      requests;
		int                      granted;
		int                      refused;
		int                      results;

		function void set_count(logic [CFG_W-1:0] v);
			count = v;
		endfunction

		// A count above the table size behaves as the full table.
		function int scan_limit();
			return (count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(count);
		endfunction

		// First entry inside the scan range that was never loaded, or -1 if there is none.
		function int first_unloaded();
			int lim;
			lim = scan_limit();
			for (int j = 0; j < lim; j++) begin
				if (!loaded[j])
					return j;
			end
			return -1;
		endfunction

		function void note_input(in_item_t it);
			int lim;
			bit found;
			int best;
			logic [SIZE_FIELD_W-1:0] best_size;
			out_item_t exp_item;
			if (it.mode == MODE_LOAD) begin
				// A load always frees the entry, even one that a request took earlier.
				sizes[it.block_index] = it.size;
				loaded[it.block_index] = 1'b1;
				taken[it.block_index] = 1'b0;
				loads++;
				return;
			end
			lim = scan_limit();
			found = 1'b0;
			best = 0;
			best_size = '0;
			// Strictly greater keeps the lowest index on a tie.
			for (int j = 0; j < lim; j++) begin
				if (!taken[j] && sizes[j] >= it.size && (!found || sizes[j] > best_size)) begin
					found = 1'b1;
					best = j;
					best_size = sizes[j];
				end
			end
			exp_item = '0;
			if (found) begin
				taken[best] = 1'b1;
				exp_item.allocated = 1'b1;
				exp_item.chosen_block = best[IDX_FIELD_W-1:0];
				exp_item.chosen_block_size = best_size;
				exp_item.leftover = best_size - it.size;
				granted++;
			end else begin
				refused++;
			end
			requests++;
			pending.push_back(exp_item);
		endfunction

		function void compare_field(string name, logic [SIZE_FIELD_W-1:0] exp_v,
				logic [SIZE_FIELD_W-1:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: MISMATCH in %s: expected %h, actual %h", $time, name, exp_v,
					act_v);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_item;
			if (pending.size() == 0) begin
				$display("%0t: result transfer with no request waiting: %h", $time, got);
				errors++;
				return;
			end
			exp_item = pending.pop_front();
			results++;
			compare_field("allocated", SIZE_FIELD_W'(exp_item.allocated),
				SIZE_FIELD_W'(got.allocated));
			compare_field("chosen_block", SIZE_FIELD_W'(exp_item.chosen_block),
				SIZE_FIELD_W'(got.chosen_block));
			compare_field("chosen_block_size", exp_item.chosen_block_size,
				got.chosen_block_size);
			compare_field("leftover", exp_item.leftover, got.leftover);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wen = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_item_t         in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_data;

	alloc_scoreboard sb;

	// When calm is set, neither side inserts any idle cycles.
	bit calm = 1'b0;
	// Set by the stimulus process to ask the result side for one long hold-off.
	bit hold_request = 1'b0;
	int settings_used = 0;

	always #5 clk = ~clk;

	worst_fit_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Idle stretch length: mostly none or short, now and then a long one.
	function automatic int idle_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_item_t load_item(int idx, int sz);
		in_item_t it;
		it.mode = MODE_LOAD;
		it.block_index = idx[IDX_FIELD_W-1:0];
		it.size = sz[SIZE_FIELD_W-1:0];
		return it;
	endfunction

	function automatic in_item_t request_item(int sz);
		in_item_t it;
		it.mode = MODE_REQUEST;
		it.block_index = IDX_FIELD_W'($urandom);
		it.size = sz[SIZE_FIELD_W-1:0];
		return it;
	endfunction

	// Random item. Requests are only issued once every entry in the scan range has been
	// loaded; until then the would-be request loads the first missing entry instead. Load
	// sizes often repeat a few round values so that ties come up, and request sizes are often
	// taken from a live entry so that exact and near fits come up.
	function automatic in_item_t pick_item();
		in_item_t it;
		int lim;
		int miss;
		int r;
		int j;
		int off;
		lim = sb.scan_limit();
		miss = sb.first_unloaded();
		it.mode = ($urandom_range(0, 99) < 55) ? MODE_REQUEST : MODE_LOAD;
		it.block_index = IDX_FIELD_W'($urandom);
		it.size = SIZE_FIELD_W'($urandom);
		r = $urandom_range(0, 9);
		if (it.mode == MODE_REQUEST && miss >= 0) begin
			it.mode = MODE_LOAD;
			it.block_index = miss[IDX_FIELD_W-1:0];
		end else if (it.mode == MODE_LOAD) begin
			if (lim > 0 && $urandom_range(0, 9) < 7)
				it.block_index = IDX_FIELD_W'($urandom_range(0, lim - 1));
			if (r == 0)
				it.size = '0;
			else if (r == 1)
				it.size = '1;
			else if (r < 5)
				it.size = SIZE_FIELD_W'(100 * $urandom_range(1, 4));
		end else begin
			if (r == 0)
				it.size = '0;
			else if (r == 1)
				it.size = '1;
			else if (r < 6 && lim > 0) begin
				j = $urandom_range(0, lim - 1);
				off = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 50);
				it.size = (sb.sizes[j] > off) ? SIZE_FIELD_W'(sb.sizes[j] - off) : sb.sizes[j];
			end else if (r < 8)
				it.size = SIZE_FIELD_W'($urandom_range(0, 1000));
		end
		return it;
	endfunction

	// Offers one item and returns at the edge where it is accepted. Valid stays high when the
	// next item follows at once, so back-to-back transfers happen without a bubble.
	task automatic send_item(in_item_t it);
		int gap;
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		sb.note_input(it);
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds the input idle until every predicted result has been transferred out.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending.size() != 0);
	endtask

	// Changes block_count between phases. Loads give no result, so after the last result
	// the block is given time to finish any trailing work before the register is written.
	task automatic set_block_count(int v);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v[CFG_W-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_count(v[CFG_W-1:0]);
		settings_used++;
	endtask

	// Result side: checks each accepted result transfer and then picks the stall for the
	// next cycle. A hold-off request from the stimulus side overrides the random pattern.
	initial begin : result_sink
		int stall_left;
		int run_left;
		int hold_left;
		stall_left = 0;
		run_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0)
				sb.check_result(out_data);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (run_left > 0)
					run_left--;
				else begin
					run_left = $urandom_range(0, 12);
					stall_left = idle_gap();
				end
			end
		end
	end

	// Watchdog: ends the run if no transfer happens on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int plan [PHASE_COUNT];
		int cnt;
		sb = new;
		sb.set_count('0);
		plan = '{32, 1, 8, 63, 0, 32, 40, 2, 16, 32, 5, 31, 20};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Right after reset block_count is zero, so a request scans nothing
		// and is refused.
		send_item(request_item(0));
		set_block_count(4);
		send_item(load_item(0, 500));
		send_item(load_item(1, 16'hFFFF));
		send_item(load_item(2, 500));
		send_item(load_item(3, 0));
		// The largest size fits a full-width request exactly.
		send_item(request_item(16'hFFFF));
		// A zero-size request takes the largest free block; blocks 0 and 2 tie and the lower
		// index wins, leaving a fragment equal to the whole block.
		send_item(request_item(0));
		// Nothing left is large enough.
		send_item(request_item(501));
		send_item(request_item(500));
		// Only the zero-size block is free, and a zero-size request still fits it.
		send_item(request_item(0));
		send_item(request_item(0));
		// Reloading a used block frees it again.
		send_item(load_item(1, 1234));
		send_item(request_item(1000));
		// An entry beyond block_count is never considered.
		send_item(load_item(4, 7));
		send_item(request_item(7));
		send_item(load_item(31, 16'hFFFF));

		// Random part, in phases with different block counts. Phase two also runs the long
		// receiver hold-off while the sender keeps offering, and every fourth phase runs
		// without idle cycles. Once in a while the sender pauses until all results are in.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			cnt = (p == PHASE_COUNT - 1) ? $urandom_range(0, 63) : plan[p];
			set_block_count(cnt);
			calm = (p % 4 == 3);
			if (p == 2)
				hold_request = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_item(pick_item());
				if ($urandom_range(0, 99) == 0)
					drain();
			end
		end

		calm = 1'b0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d input transfers (%0d loads, %0d requests) over %0d count settings",
			sb.loads + sb.requests, sb.loads, sb.requests, settings_used);
		$display("Checked %0d results: %0d blocks granted, %0d requests refused",
			sb.results, sb.granted, sb.refused);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
